// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression that must never be true out of reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/core/csa_pkg.sv -----
package csa_pkg;

	// default map size
	localparam int SLOT_COUNT_DEF = 128;

	// request opcodes
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// fit policies
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_NEXT  = 2'd1;
	localparam logic [1:0] POL_BEST  = 2'd2;
	localparam logic [1:0] POL_WORST = 2'd3;

	// result status codes
	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_NOSPACE = 2'd1,
		STAT_TOOLONG = 2'd2
	} stat_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK_RD,
		S_WALK_CHK,
		S_SCAN,
		S_MARK,
		S_RELEASE
	} state_t;

endpackage

// ----- rtl/core/contiguous_slot_allocator_top.sv -----
// Allocate: one read per slot during the scan, then one write per slot to mark run_length slots.
// Next fit first walks back over a free run (a read and a check state per slot) and may scan the map twice.
// Release: one write per cleared slot; the result strobe follows the last step.
// One request at a time; the next is taken from the strobe cycle on.
// Reset: async, active low; a clearing pass (busy high) frees all slots.
// done is a one-cycle strobe; the receiver cannot stall.
`include "assert_macros.svh"

module contiguous_slot_allocator_top #(
	parameter int SLOT_COUNT = csa_pkg::SLOT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [7:0]  run_length,
	input  logic [6:0]  release_start,
	// result channel
	output logic        done,
	output logic [1:0]  status,
	output logic [6:0]  granted_start,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import csa_pkg::*;

	localparam int IW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int LW = (CW > 8) ? CW : 8;
	localparam int PW = ((IW > 7) ? IW : 7) + 1;

	localparam logic [IW:0]   SLOTS_I  = (IW + 1)'(SLOT_COUNT);
	localparam logic [LW-1:0] SLOTS_L  = LW'(SLOT_COUNT);
	localparam logic [PW-1:0] SLOTS_P  = PW'(SLOT_COUNT);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

	// configuration register
	logic [1:0] fit_policy_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {30'd0, fit_policy_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q <= POL_FIRST;
		end else if (cfg_wr) begin
			fit_policy_q <= pwdata[1:0];
		end
	end

	// control and search registers
	state_t        state_q, state_d;
	logic [IW-1:0] cur_q, cur_d;
	logic [IW-1:0] clr_ptr_q, clr_ptr_d;
	logic [CW-1:0] len_q, len_d;
	logic [IW:0]   iss_q, iss_d;
	logic [CW-1:0] run_cnt_q, run_cnt_d;
	logic [IW-1:0] run_start_q, run_start_d;
	logic [CW-1:0] best_size_q, best_size_d;
	logic [IW-1:0] best_start_q, best_start_d;
	logic          found_q, found_d;
	logic          pass_q, pass_d;
	logic [IW-1:0] mark_ptr_q, mark_ptr_d;
	logic [CW-1:0] mark_left_q, mark_left_d;
	logic [PW-1:0] rel_ptr_q, rel_ptr_d;
	logic [7:0]    rel_left_q, rel_left_d;
	logic          done_q, done_d;
	stat_t         status_q, status_d;
	logic [6:0]    granted_q, granted_d;

	// occupancy memory, one read or write port in use per cycle
	logic          busy_mem [SLOT_COUNT];
	logic          wr_en, wr_data;
	logic [IW-1:0] wr_addr;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          rd_data_s1;
	logic [IW-1:0] rd_idx_s1;
	logic          rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			busy_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= busy_mem[rd_addr];
			rd_idx_s1  <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	// per-slot scan terms
	logic          is_last;
	logic [CW-1:0] cur_size;
	logic [CW-1:0] fit_start_w;
	logic [IW-1:0] cand_start;
	logic          better;
	logic          upd;

	always_comb begin
		is_last     = (rd_idx_s1 == LAST_IDX);
		cur_size    = rd_data_s1 ? run_cnt_q : run_cnt_q + CW'(1);
		fit_start_w = CW'(rd_idx_s1) + CW'(1) - len_q;
		cand_start  = (run_cnt_q == '0) ? rd_idx_s1 : run_start_q;
		better      = (fit_policy_q == POL_BEST) ? (cur_size < best_size_q)
		                                         : (cur_size > best_size_q);
		upd         = (rd_data_s1 || is_last) && (cur_size >= len_q)
		              && (!found_q || better);
	end

	// sequencer: next state, register updates, memory port
	always_comb begin
		state_d      = state_q;
		cur_d        = cur_q;
		clr_ptr_d    = clr_ptr_q;
		len_d        = len_q;
		iss_d        = iss_q;
		run_cnt_d    = run_cnt_q;
		run_start_d  = run_start_q;
		best_size_d  = best_size_q;
		best_start_d = best_start_q;
		found_d      = found_q;
		pass_d       = pass_q;
		mark_ptr_d   = mark_ptr_q;
		mark_left_d  = mark_left_q;
		rel_ptr_d    = rel_ptr_q;
		rel_left_d   = rel_left_q;
		done_d       = 1'b0;
		status_d     = status_q;
		granted_d    = granted_q;
		wr_en        = 1'b0;
		wr_addr      = clr_ptr_q;
		wr_data      = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = cur_q;

		unique case (state_q)
			S_CLEAR: begin
				wr_en     = 1'b1;
				wr_addr   = clr_ptr_q;
				clr_ptr_d = clr_ptr_q + IW'(1);
				if (clr_ptr_q == LAST_IDX) begin
					state_d = S_IDLE;
				end
			end

			S_IDLE: begin
				if (start) begin
					found_d     = 1'b0;
					pass_d      = 1'b0;
					run_cnt_d   = '0;
					best_size_d = '0;
					len_d       = CW'(run_length);
					if (opcode == OP_RELEASE) begin
						rel_ptr_d  = PW'(release_start);
						rel_left_d = run_length;
						state_d    = S_RELEASE;
					end else if (LW'(run_length) > SLOTS_L) begin
						done_d    = 1'b1;
						status_d  = STAT_TOOLONG;
						granted_d = '0;
					end else if (run_length == 8'd0) begin
						done_d    = 1'b1;
						status_d  = STAT_NOSPACE;
						granted_d = '0;
					end else if (fit_policy_q == POL_NEXT) begin
						state_d = S_WALK_RD;
					end else begin
						iss_d   = '0;
						state_d = S_SCAN;
					end
				end
			end

			// next fit: step the cursor back over a free run
			S_WALK_RD: begin
				rd_en   = 1'b1;
				rd_addr = cur_q;
				state_d = S_WALK_CHK;
			end

			S_WALK_CHK: begin
				if (rd_data_s1 || cur_q == '0) begin
					iss_d     = (IW + 1)'(cur_q);
					run_cnt_d = '0;
					state_d   = S_SCAN;
				end else begin
					cur_d   = cur_q - IW'(1);
					state_d = S_WALK_RD;
				end
			end

			S_SCAN: begin
				rd_en   = (iss_q < SLOTS_I);
				rd_addr = iss_q[IW-1:0];
				if (rd_en) begin
					iss_d = iss_q + (IW + 1)'(1);
				end
				if (rd_vld_s1) begin
					run_cnt_d = rd_data_s1 ? '0 : cur_size;
					if (!fit_policy_q[1]) begin
						// first / next fit: earliest end of a long enough free run
						if (!rd_data_s1 && cur_size >= len_q) begin
							best_start_d = fit_start_w[IW-1:0];
							mark_ptr_d   = fit_start_w[IW-1:0];
							mark_left_d  = len_q;
							state_d      = S_MARK;
						end else if (is_last) begin
							if (fit_policy_q == POL_NEXT && !pass_q && cur_q != '0) begin
								// wrap to slot 0 for the second pass
								pass_d    = 1'b1;
								iss_d     = '0;
								run_cnt_d = '0;
							end else begin
								done_d    = 1'b1;
								status_d  = STAT_NOSPACE;
								granted_d = '0;
								state_d   = S_IDLE;
							end
						end
					end else begin
						// best / worst fit: judge each maximal free run as it closes
						if (!rd_data_s1 && run_cnt_q == '0) begin
							run_start_d = rd_idx_s1;
						end
						if (upd) begin
							found_d      = 1'b1;
							best_size_d  = cur_size;
							best_start_d = cand_start;
						end
						if (is_last) begin
							if (found_q || upd) begin
								mark_ptr_d  = upd ? cand_start : best_start_q;
								mark_left_d = len_q;
								state_d     = S_MARK;
							end else begin
								done_d    = 1'b1;
								status_d  = STAT_NOSPACE;
								granted_d = '0;
								state_d   = S_IDLE;
							end
						end
					end
				end
			end

			S_MARK: begin
				wr_en       = 1'b1;
				wr_addr     = mark_ptr_q;
				wr_data     = 1'b1;
				mark_ptr_d  = mark_ptr_q + IW'(1);
				mark_left_d = mark_left_q - CW'(1);
				if (mark_left_q == CW'(1)) begin
					done_d    = 1'b1;
					status_d  = STAT_DONE;
					granted_d = 7'(best_start_q);
					if (fit_policy_q == POL_NEXT) begin
						cur_d = mark_ptr_q;
					end
					state_d = S_IDLE;
				end
			end

			S_RELEASE: begin
				if (rel_left_q == 8'd0 || rel_ptr_q >= SLOTS_P) begin
					done_d    = 1'b1;
					status_d  = STAT_DONE;
					granted_d = '0;
					state_d   = S_IDLE;
				end else begin
					wr_en      = 1'b1;
					wr_addr    = rel_ptr_q[IW-1:0];
					wr_data    = 1'b0;
					rel_ptr_d  = rel_ptr_q + PW'(1);
					rel_left_d = rel_left_q - 8'd1;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			cur_q     <= '0;
			clr_ptr_q <= '0;
			found_q   <= 1'b0;
			pass_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_q     <= cur_d;
			clr_ptr_q <= clr_ptr_d;
			found_q   <= found_d;
			pass_q    <= pass_d;
			done_q    <= done_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		len_q        <= len_d;
		iss_q        <= iss_d;
		run_cnt_q    <= run_cnt_d;
		run_start_q  <= run_start_d;
		best_size_q  <= best_size_d;
		best_start_q <= best_start_d;
		mark_ptr_q   <= mark_ptr_d;
		mark_left_q  <= mark_left_d;
		rel_ptr_q    <= rel_ptr_d;
		rel_left_q   <= rel_left_d;
		status_q     <= status_d;
		granted_q    <= granted_d;
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign granted_start = granted_q;

	// checks; rejected lengths answer at once without going busy
	`ASSERT_CLK(a_req_takes_busy, (start && !busy) |=> (busy || done), "accepted request dropped")
	`ASSERT_CLK(a_done_after_work, done |-> $past(busy || start), "result strobe without request")
	`ASSERT_CLK(a_reject_no_start, (done && (status != STAT_DONE)) |-> (granted_start == '0),
		"rejected request carries a start slot")
	`ASSERT_NEVER(a_cursor_range, ((IW + 1)'(cur_q) >= SLOTS_I), "next fit cursor out of map")

endmodule
